@@ rtl/core/csu_pkg.sv @@
// Package for the calendar step unit: transfer payload types, stage types,
// command and bound-status codes, and the month-length and weekday helpers.
// No dependencies.
package csu_pkg;

    // Command codes.
    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_SEC_UP   = 4'd1;
    localparam logic [3:0] CMD_SEC_DOWN = 4'd2;
    localparam logic [3:0] CMD_MIN_UP   = 4'd3;
    localparam logic [3:0] CMD_MIN_DOWN = 4'd4;
    localparam logic [3:0] CMD_HR_UP    = 4'd5;
    localparam logic [3:0] CMD_HR_DOWN  = 4'd6;
    localparam logic [3:0] CMD_DAY_UP   = 4'd7;
    localparam logic [3:0] CMD_DAY_DOWN = 4'd8;

    // Bound status codes.
    localparam logic [1:0] BOUND_WITHIN = 2'd0;
    localparam logic [1:0] BOUND_BEFORE = 2'd1;
    localparam logic [1:0] BOUND_AFTER  = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W     = 2;
    localparam logic [1:0]  CFG_LOWER_BOUND = 2'd0;
    localparam logic [1:0]  CFG_UPPER_BOUND = 2'd1;
    localparam int          BOUND_W         = 42;

    // Field limits.
    localparam logic [13:0] YEAR_MIN = 14'd2;
    localparam logic [13:0] YEAR_MAX = 14'd9998;
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [4:0]  HOUR_MAX = 5'd23;
    localparam logic [5:0]  MIN_MAX  = 6'd59;
    localparam logic [5:0]  SEC_MAX  = 6'd59;

    // floor(y / 100) for y < 10000 is (y * 5243) >> 19.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
    } item_t;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [2:0]  weekday;
        logic [4:0]  month_length;
        logic [1:0]  bound_status;
    } result_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } stamp_t;

    // Stage 1 output: sanitized timestamp plus command.
    typedef struct packed {
        logic [3:0] cmd;
        stamp_t     stamp;
    } clean_t;

    // Stage 3 output: stepped timestamp, month length, bound status and weekday partial terms.
    typedef struct packed {
        stamp_t      stamp;
        logic [4:0]  month_length;
        logic [1:0]  bound_status;
        logic [6:0]  day_term;
        logic [13:0] year_term;
        logic [6:0]  century;
    } annot_t;

    // Days in a month; a year divisible by four is a leap year.
    function automatic logic [4:0] month_len(input logic [13:0] year, input logic [3:0] month);
        logic [4:0] len;
        len = 5'd31;
        if (month == 4'd2)
        begin
            len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end
        else if (month inside {4'd4, 4'd6, 4'd9, 4'd11})
        begin
            len = 5'd30;
        end
        return len;
    endfunction

    // floor(3 * (m + 1) / 5) for the shifted month m in 3..14.
    function automatic logic [3:0] month_term(input logic [3:0] m);
        logic [3:0] v;
        case (m)
            4'd3:    v = 4'd2;
            4'd4:    v = 4'd3;
            4'd5:    v = 4'd3;
            4'd6:    v = 4'd4;
            4'd7:    v = 4'd4;
            4'd8:    v = 4'd5;
            4'd9:    v = 4'd6;
            4'd10:   v = 4'd6;
            4'd11:   v = 4'd7;
            4'd12:   v = 4'd7;
            4'd13:   v = 4'd8;
            4'd14:   v = 4'd9;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // Remainder by seven; since 8 is 1 mod 7, octal digits are summed and folded.
    function automatic logic [2:0] mod7(input logic [13:0] s);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = {2'b00, s[2:0]} + {2'b00, s[5:3]} + {2'b00, s[8:6]} + {2'b00, s[11:9]}
           + {3'b000, s[13:12]};
        f2 = {1'b0, f1[2:0]} + {2'b00, f1[4:3]};
        if (f2 >= 4'd7)
        begin
            f2 = f2 - 4'd7;
        end
        return f2[2:0];
    endfunction

endpackage

@@ rtl/core/calendar_step_unit.sv @@
// Top level of the calendar step unit: bound registers and the four-stage
// pipeline. Depends on csu_pkg, csu_sanitize, csu_step, csu_annotate, csu_finish.
//
//   Channel   Signals                                      Payload
//   --------  -------------------------------------------  ------------------
//   item      item_valid / item_ready / item               item_t timestamp+cmd
//   result    result_valid / result_ready / result         result_t
//   cfg       cfg_valid / cfg_ready / cfg_index / cfg_data  bound register write
//
// Each timestamp passes four register stages on its way to the result; a new
// item can be transferred every cycle while the result side does not stall.
// The stages are: clamp, step with carry ripple, annotate (month length,
// bound compare, year-by-100 multiply), and weekday fold into the result
// register. Reset empties the pipeline, sets the lower bound to zero and the
// upper bound to all ones. A stall on the result side backs up stage by
// stage; a stage that holds a bubble still takes a transfer, so nothing is
// lost or repeated. Configuration writes are always accepted.
module calendar_step_unit
    import csu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BOUND_W-1:0]     cfg_data
);

    logic [BOUND_W-1:0] lower_bound_reg;
    logic [BOUND_W-1:0] upper_bound_reg;

    // Handshakes between stages.
    logic   s1_valid;
    logic   s1_ready;
    clean_t s1_data;
    logic   s2_valid;
    logic   s2_ready;
    stamp_t s2_data;
    logic   s3_valid;
    logic   s3_ready;
    annot_t s3_data;

    // The bound registers take a write in any cycle; an index past the two
    // registers is accepted and ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= '0;
            upper_bound_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_LOWER_BOUND)
            begin
                lower_bound_reg <= cfg_data;
            end
            else if (cfg_index == CFG_UPPER_BOUND)
            begin
                upper_bound_reg <= cfg_data;
            end
        end
    end

    // Stage 1: every field is clamped into its legal range, the day against
    // the length of the clamped month.
    csu_sanitize u_sanitize (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (item_valid),
        .up_ready (item_ready),
        .up_data  (item),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_data)
    );

    // Stage 2: the commanded unit moves by one and wraps ripple upward.
    csu_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    // Stage 3: month length, packed compare against both bounds (lower test
    // first), and the partial weekday sums.
    csu_annotate u_annotate (
        .clk         (clk),
        .rst_n       (rst_n),
        .lower_bound (lower_bound_reg),
        .upper_bound (upper_bound_reg),
        .up_valid    (s2_valid),
        .up_ready    (s2_ready),
        .up_data     (s2_data),
        .dn_valid    (s3_valid),
        .dn_ready    (s3_ready),
        .dn_data     (s3_data)
    );

    // Stage 4: weekday modulo seven and the output register.
    csu_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_ready (s3_ready),
        .up_data  (s3_data),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_data  (result)
    );

    // The bound registers change only through the configuration channel.
    a_bounds_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_valid) |-> ($stable(lower_bound_reg) && $stable(upper_bound_reg)))
        else $error("bound register changed without a configuration transfer");

endmodule

@@ rtl/core/csu_sanitize.sv @@
// Stage 1 of the calendar step unit: clamps every input field into its range.
// Depends on csu_pkg.
module csu_sanitize
    import csu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  item_t  up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output clean_t dn_data
);

    logic   valid_reg;
    clean_t data_reg;
    clean_t data_next;

    always_comb
    begin
        logic [4:0] len;
        data_next.cmd = up_data.cmd;

        if (up_data.in_year < YEAR_MIN)
            data_next.stamp.year = YEAR_MIN;
        else if (up_data.in_year > YEAR_MAX)
            data_next.stamp.year = YEAR_MAX;
        else
            data_next.stamp.year = up_data.in_year;

        if (up_data.in_month < MONTH_MIN)
            data_next.stamp.month = MONTH_MIN;
        else if (up_data.in_month > MONTH_MAX)
            data_next.stamp.month = MONTH_MAX;
        else
            data_next.stamp.month = up_data.in_month;

        len = month_len(data_next.stamp.year, data_next.stamp.month);
        if (up_data.in_day == 5'd0)
            data_next.stamp.day = 5'd1;
        else if (up_data.in_day > len)
            data_next.stamp.day = len;
        else
            data_next.stamp.day = up_data.in_day;

        data_next.stamp.hour   = (up_data.in_hour > HOUR_MAX) ? HOUR_MAX : up_data.in_hour;
        data_next.stamp.minute = (up_data.in_minute > MIN_MAX) ? MIN_MAX : up_data.in_minute;
        data_next.stamp.second = (up_data.in_second > SEC_MAX) ? SEC_MAX : up_data.in_second;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    a_year_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.stamp.year >= YEAR_MIN && data_reg.stamp.year <= YEAR_MAX))
        else $error("sanitized year out of range");

endmodule

@@ rtl/core/csu_step.sv @@
// Stage 2 of the calendar step unit: applies the one-unit step with its
// ripple of carries or borrows up to the year. Depends on csu_pkg.
module csu_step
    import csu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  clean_t up_data,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stamp_t dn_data
);

    logic   valid_reg;
    stamp_t data_reg;
    stamp_t data_next;

    always_comb
    begin
        stamp_t     t;
        logic [3:0] cmd;
        logic       sec_up;
        logic       sec_dn;
        logic       min_up;
        logic       min_dn;
        logic       hr_up;
        logic       hr_dn;
        logic       day_up;
        logic       day_dn;
        t   = up_data.stamp;
        cmd = up_data.cmd;

        // Each unit steps when commanded directly or when the unit below wraps.
        sec_up = (cmd == CMD_SEC_UP);
        sec_dn = (cmd == CMD_SEC_DOWN);
        min_up = (cmd == CMD_MIN_UP) || (sec_up && t.second == SEC_MAX);
        min_dn = (cmd == CMD_MIN_DOWN) || (sec_dn && t.second == 6'd0);
        hr_up  = (cmd == CMD_HR_UP) || (min_up && t.minute == MIN_MAX);
        hr_dn  = (cmd == CMD_HR_DOWN) || (min_dn && t.minute == 6'd0);
        day_up = (cmd == CMD_DAY_UP) || (hr_up && t.hour == HOUR_MAX);
        day_dn = (cmd == CMD_DAY_DOWN) || (hr_dn && t.hour == 5'd0);

        data_next = t;

        if (sec_up)
            data_next.second = (t.second == SEC_MAX) ? 6'd0 : t.second + 6'd1;
        else if (sec_dn)
            data_next.second = (t.second == 6'd0) ? SEC_MAX : t.second - 6'd1;

        if (min_up)
            data_next.minute = (t.minute == MIN_MAX) ? 6'd0 : t.minute + 6'd1;
        else if (min_dn)
            data_next.minute = (t.minute == 6'd0) ? MIN_MAX : t.minute - 6'd1;

        if (hr_up)
            data_next.hour = (t.hour == HOUR_MAX) ? 5'd0 : t.hour + 5'd1;
        else if (hr_dn)
            data_next.hour = (t.hour == 5'd0) ? HOUR_MAX : t.hour - 5'd1;

        if (day_up)
        begin
            if (t.day < month_len(t.year, t.month))
            begin
                data_next.day = t.day + 5'd1;
            end
            else
            begin
                data_next.day = 5'd1;
                if (t.month == MONTH_MAX)
                begin
                    data_next.month = MONTH_MIN;
                    data_next.year  = t.year + 14'd1;
                end
                else
                begin
                    data_next.month = t.month + 4'd1;
                end
            end
        end
        else if (day_dn)
        begin
            if (t.day > 5'd1)
            begin
                data_next.day = t.day - 5'd1;
            end
            else if (t.month == MONTH_MIN)
            begin
                data_next.year  = t.year - 14'd1;
                data_next.month = MONTH_MAX;
                data_next.day   = 5'd31;
            end
            else
            begin
                data_next.month = t.month - 4'd1;
                data_next.day   = month_len(t.year, t.month - 4'd1);
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    a_day_fits_month: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.month >= MONTH_MIN && data_reg.month <= MONTH_MAX
                       && data_reg.day >= 5'd1
                       && data_reg.day <= month_len(data_reg.year, data_reg.month)))
        else $error("stepped date is not a valid calendar date");

endmodule

@@ rtl/core/csu_annotate.sv @@
// Stage 3 of the calendar step unit: month length, bound comparison and the
// partial weekday terms, including the year-by-100 quotient. Depends on csu_pkg.
module csu_annotate
    import csu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BOUND_W-1:0] lower_bound,
    input  logic [BOUND_W-1:0] upper_bound,
    input  logic               up_valid,
    output logic               up_ready,
    input  stamp_t             up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output annot_t             dn_data
);

    logic   valid_reg;
    annot_t data_reg;
    annot_t data_next;

    always_comb
    begin
        logic [BOUND_W-1:0] packed_stamp;
        logic [3:0]         mz;
        logic [13:0]        yz;
        logic [26:0]        prod;
        packed_stamp = {2'b00, up_data.year, up_data.month, up_data.day,
                        up_data.hour, up_data.minute, up_data.second};

        data_next.stamp        = up_data;
        data_next.month_length = month_len(up_data.year, up_data.month);

        if (packed_stamp < lower_bound)
            data_next.bound_status = BOUND_BEFORE;
        else if (packed_stamp > upper_bound)
            data_next.bound_status = BOUND_AFTER;
        else
            data_next.bound_status = BOUND_WITHIN;

        // January and February count as months 13 and 14 of the previous year.
        if (up_data.month <= 4'd2)
        begin
            mz = up_data.month + 4'd12;
            yz = up_data.year - 14'd1;
        end
        else
        begin
            mz = up_data.month;
            yz = up_data.year;
        end

        data_next.day_term  = {2'b00, up_data.day} + {2'b00, mz, 1'b0}
                            + {3'b000, month_term(mz)};
        data_next.year_term = yz + {2'b00, yz[13:2]};
        prod                = {13'd0, yz} * {14'd0, DIV100_MUL};
        data_next.century   = prod[DIV100_SHIFT +: 7];
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    a_month_length_matches: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.month_length
                       == month_len(data_reg.stamp.year, data_reg.stamp.month)))
        else $error("month length does not follow the stepped date");

endmodule

@@ rtl/core/csu_finish.sv @@
// Stage 4 of the calendar step unit: completes the weekday congruence and
// holds the result register that faces the output channel. Depends on csu_pkg.
module csu_finish
    import csu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    output logic    up_ready,
    input  annot_t  up_data,
    output logic    dn_valid,
    input  logic    dn_ready,
    output result_t dn_data
);

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;

    always_comb
    begin
        logic [13:0] sum;
        // The year term always covers the century term, so this cannot underflow.
        sum = up_data.year_term + {7'd0, up_data.day_term} - {7'd0, up_data.century}
            + {9'd0, up_data.century[6:2]};

        data_next.out_year     = up_data.stamp.year;
        data_next.out_month    = up_data.stamp.month;
        data_next.out_day      = up_data.stamp.day;
        data_next.out_hour     = up_data.stamp.hour;
        data_next.out_minute   = up_data.stamp.minute;
        data_next.out_second   = up_data.stamp.second;
        data_next.weekday      = mod7(sum);
        data_next.month_length = up_data.month_length;
        data_next.bound_status = up_data.bound_status;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.weekday <= 3'd6))
        else $error("weekday out of range");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.bound_status == BOUND_WITHIN
                       || data_reg.bound_status == BOUND_BEFORE
                       || data_reg.bound_status == BOUND_AFTER))
        else $error("bound status code out of range");

endmodule
